// File: src/slm_pkg.sv
// shared types, constants and the double compare for the sorted list merge
`default_nettype none
package slm_pkg;
  localparam int unsigned ListCapacity = 32;

  localparam logic [1:0] CMD_LOAD_EXIST = 2'd0;
  localparam logic [1:0] CMD_LOAD_NEW = 2'd1;
  localparam logic [1:0] CMD_MERGE = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EXIST_UNSORTED = 3'd1;
  localparam logic [2:0] ST_NEW_UNSORTED = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic [1:0] cmd;
    logic [63:0] value;
  } in_word_t;

  typedef struct packed {
    logic [63:0] merged_value;
    logic last;
    logic [2:0] status;
  } out_word_t;

  function automatic logic is_nan(input logic [63:0] a);
    is_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
  endfunction

  // strict ieee less-than, false on nan, +0 equals -0
  function automatic logic dbl_lt(input logic [63:0] a, input logic [63:0] b);
    logic res;
    res = 1'b0;
    if (is_nan(a) || is_nan(b)) begin
      res = 1'b0;
    end else if (a[62:0] == 63'd0 && b[62:0] == 63'd0) begin
      res = 1'b0;
    end else if (a[63] != b[63]) begin
      res = a[63];
    end else if (!a[63]) begin
      res = a[62:0] < b[62:0];
    end else begin
      res = a[62:0] > b[62:0];
    end
    dbl_lt = res;
  endfunction
endpackage
`default_nettype wire

// File: src/slm_list.sv
// one list store with its fill count, sorted flag and registered read port
`default_nettype none
module slm_list #(
  parameter int unsigned CAP = slm_pkg::ListCapacity
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic wr,
  input wire logic [63:0] wdata,
  input wire logic clear,
  input wire logic [$clog2(CAP+1)-1:0] raddr,
  output logic [63:0] rdata,
  output logic [$clog2(CAP+1)-1:0] count,
  output logic sorted,
  output logic full
);
  localparam int unsigned AW = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int unsigned CW = $clog2(CAP+1);
  logic [63:0] mem [CAP];
  logic [63:0] tail;

  assign full = (count == CW'(CAP));

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[count[AW-1:0]] <= wdata;
    end
    rdata <= mem[raddr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      tail <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
      sorted <= 1'b1;
    end else if (wr && !full) begin
      count <= count + CW'(1);
      if (count != '0 && slm_pkg::dbl_lt(wdata, tail)) begin
        sorted <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: src/sorted_list_merge_top.sv
// top level of the sorted list merge: command decode and merge sequencer
// A load gives no word unless the list is full. A merge holds busy from
// its priming read to its last word: each cycle one shared compare picks
// between the registered heads of the two stores, whose single read ports
// set the pace of one word per cycle after the priming read.
// Error and empty merges give one status word. Words are strobed by valid
// for one cycle; the receiver cannot stall.
`default_nettype none
module sorted_list_merge_top #(
  parameter int unsigned LIST_CAPACITY = slm_pkg::ListCapacity
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire slm_pkg::in_word_t in_word,
  output logic valid,
  output slm_pkg::out_word_t out_word
);
  localparam int unsigned CW = $clog2(LIST_CAPACITY+1);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PRIME = 2'd1;
  localparam logic [1:0] S_RUN = 2'd2;

  logic [1:0] state;
  logic accept;
  logic [CW-1:0] ie, jn, ie_next, jn_next, ne, nn;
  logic [63:0] de, dn;
  logic se, sn, fe, fn, clr, take_e, end_run;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);

  slm_list #(.CAP(LIST_CAPACITY)) u_exist (
    .clk, .rst,
    .wr(accept && in_word.cmd == slm_pkg::CMD_LOAD_EXIST), .wdata(in_word.value),
    .clear(clr), .raddr(ie_next), .rdata(de), .count(ne), .sorted(se), .full(fe)
  );
  slm_list #(.CAP(LIST_CAPACITY)) u_new (
    .clk, .rst,
    .wr(accept && in_word.cmd == slm_pkg::CMD_LOAD_NEW), .wdata(in_word.value),
    .clear(clr), .raddr(jn_next), .rdata(dn), .count(nn), .sorted(sn), .full(fn)
  );

  always_comb begin
    take_e = 1'b0;
    if (ie < ne && jn < nn) begin
      take_e = slm_pkg::dbl_lt(de, dn);
    end else begin
      take_e = (ie < ne);
    end
    ie_next = ie;
    jn_next = jn;
    if (state == S_RUN) begin
      if (take_e) begin
        ie_next = ie + CW'(1);
      end else begin
        jn_next = jn + CW'(1);
      end
    end else if (state == S_IDLE) begin
      ie_next = '0;
      jn_next = '0;
    end
    end_run = (state == S_RUN) && ({1'b0, ie_next} + {1'b0, jn_next} == {1'b0, ne} + {1'b0, nn});
    clr = end_run || (accept && in_word.cmd == slm_pkg::CMD_MERGE &&
          (!se || !sn || (ne == '0 && nn == '0)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_word.cmd)
              slm_pkg::CMD_LOAD_EXIST: valid <= fe;
              slm_pkg::CMD_LOAD_NEW: valid <= fn;
              slm_pkg::CMD_MERGE: begin
                if (!se || !sn || (ne == '0 && nn == '0)) begin
                  valid <= 1'b1;
                end else begin
                  state <= S_PRIME;
                end
              end
              default: ;
            endcase
          end
        end
        S_PRIME: state <= S_RUN;
        S_RUN: begin
          valid <= 1'b1;
          if (end_run) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ie <= ie_next;
    jn <= jn_next;
    if (state == S_RUN) begin
      out_word.merged_value <= take_e ? de : dn;
      out_word.last <= end_run;
      out_word.status <= slm_pkg::ST_OK;
    end else begin
      out_word.merged_value <= '0;
      out_word.last <= 1'b1;
      if (in_word.cmd != slm_pkg::CMD_MERGE) begin
        out_word.status <= slm_pkg::ST_FULL;
      end else if (!se) begin
        out_word.status <= slm_pkg::ST_EXIST_UNSORTED;
      end else if (!sn) begin
        out_word.status <= slm_pkg::ST_NEW_UNSORTED;
      end else begin
        out_word.status <= slm_pkg::ST_EMPTY;
      end
    end
  end
endmodule
`default_nettype wire

// File: tb/sv/sorted_list_merge_top_tb.sv
// testbench for the sorted list merge: directed and random loads and merges
`default_nettype none
module sorted_list_merge_top_tb;

  localparam int unsigned Depth = slm_pkg::ListCapacity;
  localparam int unsigned StallLimit = 2000;
  localparam logic [1:0] CmdUnused = 2'd3;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  slm_pkg::in_word_t in_word;
  logic valid;
  slm_pkg::out_word_t out_word;

  sorted_list_merge_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .valid(valid),
    .out_word(out_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  logic [63:0] exist_list[Depth];
  logic [63:0] new_list[Depth];
  int unsigned exist_count;
  int unsigned new_count;
  logic exist_sorted;
  logic new_sorted;

  slm_pkg::out_word_t pending_words[$];
  int unsigned errors;
  int unsigned words_seen;
  int unsigned merges_sent;
  int unsigned idle_pct;
  int unsigned quiet_cycles;
  logic timed_out;

  // own double compare: strict less-than, false on nan, signed zeros equal
  function automatic logic fp_less(input logic [63:0] a, input logic [63:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
    b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
    if (a_nan || b_nan) return 1'b0;
    if (a[62:0] == 63'd0 && b[62:0] == 63'd0) return 1'b0;
    if (a[63] != b[63]) return a[63];
    if (!a[63]) return a[62:0] < b[62:0];
    return a[62:0] > b[62:0];
  endfunction

  function automatic slm_pkg::out_word_t status_word(input logic [2:0] code);
    slm_pkg::out_word_t w;
    w.merged_value = '0;
    w.last = 1'b1;
    w.status = code;
    return w;
  endfunction

  function automatic void clear_lists();
    exist_count = 0;
    new_count = 0;
    exist_sorted = 1'b1;
    new_sorted = 1'b1;
  endfunction

  task automatic predict_word(input slm_pkg::in_word_t w);
    int unsigned i;
    int unsigned j;
    int unsigned total;
    slm_pkg::out_word_t o;
    i = 0;
    j = 0;
    case (w.cmd)
      slm_pkg::CMD_LOAD_EXIST: begin
        if (exist_count >= Depth) begin
          pending_words.push_back(status_word(slm_pkg::ST_FULL));
        end else begin
          if (exist_count > 0 && fp_less(w.value, exist_list[exist_count-1]))
            exist_sorted = 1'b0;
          exist_list[exist_count] = w.value;
          exist_count++;
        end
      end
      slm_pkg::CMD_LOAD_NEW: begin
        if (new_count >= Depth) begin
          pending_words.push_back(status_word(slm_pkg::ST_FULL));
        end else begin
          if (new_count > 0 && fp_less(w.value, new_list[new_count-1]))
            new_sorted = 1'b0;
          new_list[new_count] = w.value;
          new_count++;
        end
      end
      slm_pkg::CMD_MERGE: begin
        total = exist_count + new_count;
        if (!exist_sorted) begin
          pending_words.push_back(status_word(slm_pkg::ST_EXIST_UNSORTED));
        end else if (!new_sorted) begin
          pending_words.push_back(status_word(slm_pkg::ST_NEW_UNSORTED));
        end else if (total == 0) begin
          pending_words.push_back(status_word(slm_pkg::ST_EMPTY));
        end else begin
          for (int unsigned k = 0; k < total; k++) begin
            if (i < exist_count && j < new_count) begin
              if (fp_less(exist_list[i], new_list[j])) o.merged_value = exist_list[i++];
              else o.merged_value = new_list[j++];
            end else if (i < exist_count) begin
              o.merged_value = exist_list[i++];
            end else begin
              o.merged_value = new_list[j++];
            end
            o.last = (k + 1 == total);
            o.status = slm_pkg::ST_OK;
            pending_words.push_back(o);
          end
        end
        clear_lists();
        merges_sent++;
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_word(input logic [1:0] cmd, input logic [63:0] value);
    slm_pkg::in_word_t w;
    w.cmd = cmd;
    w.value = value;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_word(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // special values for the lists: signed zeros, infinities, nan, a denormal and one
  function automatic logic [63:0] special_value(input int unsigned sel);
    case (sel)
      0: return 64'h0000_0000_0000_0000;
      1: return 64'h8000_0000_0000_0000;
      2: return 64'h7ff0_0000_0000_0000;
      3: return 64'hfff0_0000_0000_0000;
      4: return 64'h7ff8_0000_0000_0001;
      5: return 64'hffff_ffff_ffff_ffff;
      6: return 64'h0000_0000_0000_0001;
      default: return 64'h3ff0_0000_0000_0000;
    endcase
  endfunction

  function automatic logic [63:0] rand_double();
    return {$urandom(), $urandom()};
  endfunction

  // ascending run of n random doubles: start low and climb by small steps, sometimes repeating a value
  task automatic load_sorted(input logic [1:0] cmd, input int unsigned n);
    logic [63:0] v;
    v = {1'b0, 11'($urandom_range(900, 1000)), 20'($urandom()), 32'($urandom())};
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) v = v;
      else v = v + {$urandom_range(0, 3), 32'($urandom())};
      send_word(cmd, v);
    end
  endtask

  task automatic test_directed();
    send_word(slm_pkg::CMD_MERGE, '0);
    send_word(slm_pkg::CMD_LOAD_EXIST, 64'h8000_0000_0000_0000);
    send_word(slm_pkg::CMD_LOAD_EXIST, 64'h0000_0000_0000_0000);
    send_word(slm_pkg::CMD_LOAD_EXIST, 64'h7ff8_0000_0000_0001);
    send_word(slm_pkg::CMD_LOAD_EXIST, 64'h3ff0_0000_0000_0000);
    send_word(slm_pkg::CMD_LOAD_NEW, 64'hfff0_0000_0000_0000);
    send_word(slm_pkg::CMD_LOAD_NEW, 64'h0000_0000_0000_0000);
    send_word(slm_pkg::CMD_LOAD_NEW, 64'h3ff0_0000_0000_0000);
    send_word(slm_pkg::CMD_LOAD_NEW, 64'h7ff0_0000_0000_0000);
    send_word(CmdUnused, 64'hffff_ffff_ffff_ffff);
    send_word(slm_pkg::CMD_MERGE, '1);
    send_word(slm_pkg::CMD_LOAD_EXIST, 64'h4000_0000_0000_0000);
    send_word(slm_pkg::CMD_LOAD_EXIST, 64'h3ff0_0000_0000_0000);
    send_word(slm_pkg::CMD_LOAD_NEW, 64'h4000_0000_0000_0000);
    send_word(slm_pkg::CMD_LOAD_NEW, 64'h3ff0_0000_0000_0000);
    send_word(slm_pkg::CMD_MERGE, '0);
    send_word(slm_pkg::CMD_LOAD_NEW, 64'h4000_0000_0000_0000);
    send_word(slm_pkg::CMD_LOAD_NEW, 64'h3ff0_0000_0000_0000);
    send_word(slm_pkg::CMD_MERGE, '0);
    send_word(slm_pkg::CMD_LOAD_NEW, 64'h7ff0_0000_0000_0000);
    send_word(slm_pkg::CMD_MERGE, '0);
  endtask

  task automatic test_full_lists();
    load_sorted(slm_pkg::CMD_LOAD_EXIST, Depth);
    send_word(slm_pkg::CMD_LOAD_EXIST, '1);
    load_sorted(slm_pkg::CMD_LOAD_NEW, Depth);
    send_word(slm_pkg::CMD_LOAD_NEW, '0);
    send_word(slm_pkg::CMD_MERGE, '0);
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned kind;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(9);
      if (kind < 6) begin
        // mostly short sorted lists, sometimes near full
        int unsigned ne;
        int unsigned nn;
        ne = ($urandom_range(7) == 0) ? $urandom_range(Depth) : $urandom_range(6);
        nn = ($urandom_range(7) == 0) ? $urandom_range(Depth) : $urandom_range(6);
        load_sorted(slm_pkg::CMD_LOAD_EXIST, ne);
        load_sorted(slm_pkg::CMD_LOAD_NEW, nn);
        if ($urandom_range(4) == 0)
          send_word(slm_pkg::CMD_LOAD_NEW, special_value($urandom_range(7)));
        send_word(slm_pkg::CMD_MERGE, rand_double());
        sent += ne + nn + 1;
      end else begin
        for (int unsigned k = 0; k < 4; k++) begin
          if ($urandom_range(1)) send_word(2'($urandom_range(3)), rand_double());
          else send_word(2'($urandom_range(3)), special_value($urandom_range(7)));
        end
        send_word(slm_pkg::CMD_MERGE, rand_double());
        sent += 5;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && valid) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_word);
        errors++;
      end else begin
        slm_pkg::out_word_t e;
        e = pending_words.pop_front();
        if (out_word.merged_value !== e.merged_value || out_word.last !== e.last ||
            out_word.status !== e.status) begin
          $display("%0t: mismatch expected value %h last %b status %0d, got %h %b %0d",
                   $time, e.merged_value, e.last, e.status,
                   out_word.merged_value, out_word.last, out_word.status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted word in either direction
  always @(posedge clk) begin
    if (rst || valid || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) timed_out <= 1'b1;
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    in_word = '0;
    errors = 0;
    words_seen = 0;
    merges_sent = 0;
    idle_pct = 0;
    quiet_cycles = 0;
    timed_out = 1'b0;
    clear_lists();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fork
      begin
        test_directed();
        test_full_lists();
        idle_pct = 0;
        test_random(68);
        idle_pct = 47;
        test_random(68);
        idle_pct = 0;
        test_random(68);
        idle_pct = 28;
        test_random(68);
        drain();
      end
      begin
        wait (timed_out);
      end
    join_any
    if (timed_out) begin
      $display("timeout with %0d words outstanding", pending_words.size());
      $display("sorted_list_merge_top_tb: done, errors");
      $finish;
    end
    $display("ran ties, signed zeros, nan, full lists, unsorted and empty merges,");
    $display("with and without sender gaps: %0d merges, %0d output words, %0d left over",
             merges_sent, words_seen, pending_words.size());
    if (errors == 0 && pending_words.size() == 0) begin
      $display("sorted_list_merge_top_tb: done, clean");
    end else begin
      $display("sorted_list_merge_top_tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
